// File: hw/rtl/four_channel_window_average_assert.svh
// Assertion macros used by the checker of the window average block
`ifndef FOUR_CHANNEL_WINDOW_AVERAGE_ASSERT_SVH
`define FOUR_CHANNEL_WINDOW_AVERAGE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define FCWA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcwa assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define FCWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcwa assertion failed");

`endif

// File: hw/rtl/fcwa_pkg.sv
// Shared constants, types and helpers of the window average block
package fcwa_pkg;

   localparam int MAX_WINDOW    = 1024;
   localparam int SAMPLE_BITS   = 14;
   localparam int CHANNELS      = 4;
   localparam int HELD_BITS     = $clog2(MAX_WINDOW) + 1;
   localparam int ADDR_BITS     = $clog2(MAX_WINDOW);
   localparam int SUM_BITS      = SAMPLE_BITS + ADDR_BITS;
   localparam int DIV_STEP_BITS = $clog2(SAMPLE_BITS);

   typedef logic [SAMPLE_BITS-1:0]   sample_type;
   typedef logic [SUM_BITS-1:0]      sum_type;
   typedef logic [HELD_BITS-1:0]     held_type;
   typedef logic [ADDR_BITS-1:0]     addr_type;
   typedef logic [DIV_STEP_BITS-1:0] div_step_type;

   localparam held_type WINDOW_RESET = held_type'(MAX_WINDOW);

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV_START,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic update;
      logic div_start;
      logic out_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_done;
   } status_type;

   // Window length as used: zero means one, large values saturate
   function automatic held_type effective_length(input held_type len);
      held_type result;
      if (len == '0) begin
         result = held_type'(1);
      end else if (len > WINDOW_RESET) begin
         result = WINDOW_RESET;
      end else begin
         result = len;
      end
      return result;
   endfunction

endpackage

// File: hw/rtl/fcwa_req_if.sv
// Input channel: four particulate readings per item
interface fcwa_req_if;
   logic                 valid;
   logic                 ready;
   fcwa_pkg::sample_type pm1_sample;
   fcwa_pkg::sample_type pm2_5_sample;
   fcwa_pkg::sample_type pm4_sample;
   fcwa_pkg::sample_type pm10_sample;

   modport source (
      output valid, pm1_sample, pm2_5_sample, pm4_sample, pm10_sample,
      input  ready
   );
   modport sink (
      input  valid, pm1_sample, pm2_5_sample, pm4_sample, pm10_sample,
      output ready
   );
endinterface

// File: hw/rtl/fcwa_rsp_if.sv
// Result channel: four window averages and the sample count per item
interface fcwa_rsp_if;
   logic                 valid;
   logic                 ready;
   fcwa_pkg::sample_type pm1_average;
   fcwa_pkg::sample_type pm2_5_average;
   fcwa_pkg::sample_type pm4_average;
   fcwa_pkg::sample_type pm10_average;
   fcwa_pkg::held_type   samples_held;

   modport source (
      output valid, pm1_average, pm2_5_average, pm4_average, pm10_average,
             samples_held,
      input  ready
   );
   modport sink (
      input  valid, pm1_average, pm2_5_average, pm4_average, pm10_average,
             samples_held,
      output ready
   );
endinterface

// File: hw/rtl/fcwa_ram.sv
// Generic single-port RAM with registered read
module fcwa_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 16,
   localparam int AddrBits  = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic                  rd_en,
   input  logic [AddrBits-1:0]   addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/fcwa_div.sv
// One divider lane: restoring division, one quotient bit per cycle
module fcwa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  fcwa_pkg::sum_type    dividend,
   input  fcwa_pkg::held_type   divisor,
   output fcwa_pkg::sample_type quotient,
   output logic                 done
);

   fcwa_pkg::sum_type      rem_ff, rem_in;
   fcwa_pkg::sample_type   quot_ff, quot_in;
   fcwa_pkg::div_step_type step_ff, step_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   fcwa_pkg::sum_type      trial;

   // Quotient always fits the sample width, so start at its top bit
   assign trial = fcwa_pkg::sum_type'(divisor) << step_ff;

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         quot_in = '0;
         step_in = fcwa_pkg::div_step_type'(fcwa_pkg::SAMPLE_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in           = rem_ff - trial;
            quot_in[step_ff] = 1'b1;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - fcwa_pkg::div_step_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

// File: hw/rtl/fcwa_datapath.sv
// Datapath: sample histories, running sums, window pointers, dividers, result
module fcwa_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  fcwa_pkg::cmd_type    cmd,
   output fcwa_pkg::status_type status,
   input  logic                 csr_wr_en,
   input  fcwa_pkg::held_type   csr_wr_data,
   input  fcwa_pkg::sample_type samples [fcwa_pkg::CHANNELS],
   output fcwa_pkg::sample_type averages [fcwa_pkg::CHANNELS],
   output fcwa_pkg::held_type   samples_held
);

   fcwa_pkg::held_type   window_length_ff, window_length_in;
   fcwa_pkg::held_type   fill_ff, fill_in;
   fcwa_pkg::addr_type   oldest_ff, oldest_in;
   fcwa_pkg::sum_type    sums_ff [fcwa_pkg::CHANNELS];
   fcwa_pkg::sum_type    sums_in [fcwa_pkg::CHANNELS];
   fcwa_pkg::sample_type samp_ff [fcwa_pkg::CHANNELS];
   fcwa_pkg::sample_type avg_ff  [fcwa_pkg::CHANNELS];
   fcwa_pkg::held_type   held_ff;
   fcwa_pkg::addr_type   pos_ff;
   logic                 filling_ff;

   fcwa_pkg::held_type   len;
   logic                 filling_now;
   fcwa_pkg::addr_type   pos_now;
   fcwa_pkg::addr_type   ram_addr;
   fcwa_pkg::held_type   oldest_next;
   fcwa_pkg::sample_type old_sample [fcwa_pkg::CHANNELS];
   fcwa_pkg::sample_type quotient   [fcwa_pkg::CHANNELS];
   logic [fcwa_pkg::CHANNELS-1:0] div_done;

   // Slot for the next item: next free entry while filling, else the oldest
   assign len         = fcwa_pkg::effective_length(window_length_ff);
   assign filling_now = fill_ff < len;
   assign pos_now     = filling_now ? fcwa_pkg::addr_type'(fill_ff) : oldest_ff;
   assign ram_addr    = cmd.update ? pos_ff : pos_now;
   assign oldest_next = fcwa_pkg::held_type'(oldest_ff) + fcwa_pkg::held_type'(1);

   // Window bookkeeping and sum update
   always_comb begin
      window_length_in = window_length_ff;
      fill_in          = fill_ff;
      oldest_in        = oldest_ff;
      for (int ch = 0; ch < fcwa_pkg::CHANNELS; ch++) begin
         sums_in[ch] = sums_ff[ch];
      end
      if (csr_wr_en) begin
         // a length write always empties the window
         window_length_in = csr_wr_data;
         fill_in          = '0;
         oldest_in        = '0;
         for (int ch = 0; ch < fcwa_pkg::CHANNELS; ch++) begin
            sums_in[ch] = '0;
         end
      end else if (cmd.update) begin
         for (int ch = 0; ch < fcwa_pkg::CHANNELS; ch++) begin
            sums_in[ch] = sums_ff[ch] + fcwa_pkg::sum_type'(samp_ff[ch])
                        - (filling_ff ? '0 : fcwa_pkg::sum_type'(old_sample[ch]));
         end
         if (filling_ff) begin
            fill_in = fill_ff + fcwa_pkg::held_type'(1);
         end else if (oldest_next >= len) begin
            oldest_in = '0;
         end else begin
            oldest_in = fcwa_pkg::addr_type'(oldest_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= fcwa_pkg::WINDOW_RESET;
         fill_ff          <= '0;
         oldest_ff        <= '0;
         for (int ch = 0; ch < fcwa_pkg::CHANNELS; ch++) begin
            sums_ff[ch] <= '0;
         end
      end else begin
         window_length_ff <= window_length_in;
         fill_ff          <= fill_in;
         oldest_ff        <= oldest_in;
         for (int ch = 0; ch < fcwa_pkg::CHANNELS; ch++) begin
            sums_ff[ch] <= sums_in[ch];
         end
      end
   end

   // Item capture and result register
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         samp_ff    <= samples;
         pos_ff     <= pos_now;
         filling_ff <= filling_now;
      end
      if (cmd.out_load) begin
         avg_ff  <= quotient;
         held_ff <= fill_ff;
      end
   end

   // One history memory and one divider lane per channel
   for (genvar ch = 0; ch < fcwa_pkg::CHANNELS; ch++) begin : g_chan
      fcwa_ram #(
         .DATA_WIDTH (fcwa_pkg::SAMPLE_BITS),
         .DEPTH      (fcwa_pkg::MAX_WINDOW)
      ) u_history (
         .clock   (clock),
         .wr_en   (cmd.update),
         .rd_en   (cmd.accept),
         .addr    (ram_addr),
         .wr_data (samp_ff[ch]),
         .rd_data (old_sample[ch])
      );

      fcwa_div u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (cmd.div_start),
         .dividend (sums_ff[ch]),
         .divisor  (fill_ff),
         .quotient (quotient[ch]),
         .done     (div_done[ch])
      );
   end

   // lanes run in lockstep
   assign status.div_done = &div_done;
   assign averages        = avg_ff;
   assign samples_held    = held_ff;

endmodule

// File: hw/rtl/fcwa_ctrl.sv
// Controller: sequences one item through update, divide and delivery
module fcwa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fcwa_pkg::cmd_type    cmd,
   input  fcwa_pkg::status_type status
);

   fcwa_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcwa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         fcwa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = fcwa_pkg::ST_UPDATE;
            end
         end
         fcwa_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = fcwa_pkg::ST_DIV_START;
         end
         fcwa_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = fcwa_pkg::ST_DIVIDE;
         end
         fcwa_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = fcwa_pkg::ST_DELIVER;
            end
         end
         fcwa_pkg::ST_DELIVER: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = fcwa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fcwa_pkg::ST_IDLE;
         end
      endcase
   end

   // Result valid: set on load, cleared when taken
   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/four_channel_window_average.sv
// Top level of the four-channel sliding-window moving average
//
// Usage:
//   req_if carries one item of four particulate readings (PM1, PM2.5, PM4,
//   PM10). rsp_if returns one item per input: the truncated mean of each
//   channel over the samples held, and the number of samples held.
//   csr_wr_en/csr_wr_data write the window length (1..1024; zero acts as 1,
//   larger values saturate). Every write also empties the window. Write it
//   only while no item is in flight.
// Timing:
//   An item is accepted in the idle state; the controller then steps through
//   update, divider start, divide and deliver, and takes no new item until
//   it is back in idle. The four divider lanes produce one quotient bit per
//   cycle in lockstep; memory read, sum update, divider start and handoff add to it.
// Reset:
//   Synchronous. Window length returns to 1024, the window is empty. The
//   history memories are not cleared; entries are read only once written.
// Backpressure:
//   A finished result sits in the output register while the next item is
//   already accepted and worked on; that item then waits for rsp_ready.
module four_channel_window_average (
   input  logic               clock,
   input  logic               reset,
   fcwa_req_if.sink           req_if,
   fcwa_rsp_if.source         rsp_if,
   input  logic               csr_wr_en,
   input  fcwa_pkg::held_type csr_wr_data
);

   fcwa_pkg::cmd_type    cmd;
   fcwa_pkg::status_type status;
   fcwa_pkg::sample_type samples  [fcwa_pkg::CHANNELS];
   fcwa_pkg::sample_type averages [fcwa_pkg::CHANNELS];

   // Channel order in the datapath: PM1, PM2.5, PM4, PM10
   assign samples[0] = req_if.pm1_sample;
   assign samples[1] = req_if.pm2_5_sample;
   assign samples[2] = req_if.pm4_sample;
   assign samples[3] = req_if.pm10_sample;

   assign rsp_if.pm1_average   = averages[0];
   assign rsp_if.pm2_5_average = averages[1];
   assign rsp_if.pm4_average   = averages[2];
   assign rsp_if.pm10_average  = averages[3];

   fcwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   fcwa_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .samples      (samples),
      .averages     (averages),
      .samples_held (rsp_if.samples_held)
   );

endmodule

// File: hw/rtl/fcwa_checker.sv
// Port-level checker for the window average block, bound to the top level
`include "four_channel_window_average_assert.svh"

module fcwa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input fcwa_pkg::sample_type pm1_average,
   input fcwa_pkg::sample_type pm10_average,
   input fcwa_pkg::held_type   samples_held
);

   // A stalled result stays up and keeps its payload
   `FCWA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `FCWA_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
                     $stable(samples_held) && $stable(pm1_average) && $stable(pm10_average))

   // One item at a time: no accept right after an accept
   `FCWA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // Every result counts at least the item itself and at most a full window
   `FCWA_ASSERT_IMPL(a_held_range, clock, reset, rsp_valid,
                     samples_held != '0 && samples_held <= fcwa_pkg::WINDOW_RESET)

endmodule

bind four_channel_window_average fcwa_checker u_fcwa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .pm1_average  (rsp_if.pm1_average),
   .pm10_average (rsp_if.pm10_average),
   .samples_held (rsp_if.samples_held)
);

// File: test/four_channel_window_average_test.sv
// Self-checking testbench for the four-channel sliding-window moving average
`timescale 1ns / 100ps

module four_channel_window_average_test;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_LIMIT  = 30;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_OFF_SPAN = 400;

   typedef struct packed {
      fcwa_pkg::sample_type pm1;
      fcwa_pkg::sample_type pm2_5;
      fcwa_pkg::sample_type pm4;
      fcwa_pkg::sample_type pm10;
   } readings_type;

   typedef struct packed {
      fcwa_pkg::sample_type pm1;
      fcwa_pkg::sample_type pm2_5;
      fcwa_pkg::sample_type pm4;
      fcwa_pkg::sample_type pm10;
      fcwa_pkg::held_type   held;
   } averages_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   fcwa_pkg::held_type csr_wr_data = '0;

   fcwa_req_if req_if ();
   fcwa_rsp_if rsp_if ();

   four_channel_window_average dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Window state mirrored on the testbench side
   int                   window_setting;
   int                   fill_level;
   int                   oldest_slot;
   fcwa_pkg::sum_type    window_sums [fcwa_pkg::CHANNELS];
   fcwa_pkg::sample_type pm_history [fcwa_pkg::CHANNELS][fcwa_pkg::MAX_WINDOW];
   averages_type         pending_averages [$];

   int error_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   event hold_off_kick;
   logic hold_off_active = 1'b0;

   // Length write: store the value and empty the window
   function automatic void set_window_model(input fcwa_pkg::held_type len);
      int ch;
      window_setting = len;
      fill_level = 0;
      oldest_slot = 0;
      for (ch = 0; ch < fcwa_pkg::CHANNELS; ch++) begin
         window_sums[ch] = '0;
      end
   endfunction

   // Push one reading set into the mirrored window, queue the expected averages
   function automatic void predict_averages(input readings_type r);
      fcwa_pkg::sample_type fresh [fcwa_pkg::CHANNELS];
      fcwa_pkg::sample_type mean [fcwa_pkg::CHANNELS];
      averages_type         avg;
      int                   span;
      int                   slot;
      int                   ch;
      bit                   filling;
      fresh[0] = r.pm1;
      fresh[1] = r.pm2_5;
      fresh[2] = r.pm4;
      fresh[3] = r.pm10;
      span = window_setting;
      if (span < 1) span = 1;
      if (span > fcwa_pkg::MAX_WINDOW) span = fcwa_pkg::MAX_WINDOW;
      filling = fill_level < span;
      slot = filling ? fill_level : oldest_slot;
      for (ch = 0; ch < fcwa_pkg::CHANNELS; ch++) begin
         if (!filling) begin
            window_sums[ch] = window_sums[ch] - pm_history[ch][slot];
         end
         window_sums[ch] = window_sums[ch] + fresh[ch];
         pm_history[ch][slot] = fresh[ch];
      end
      if (filling) begin
         fill_level++;
      end else begin
         oldest_slot = (oldest_slot + 1 >= span) ? 0 : oldest_slot + 1;
      end
      for (ch = 0; ch < fcwa_pkg::CHANNELS; ch++) begin
         mean[ch] = fcwa_pkg::sample_type'(window_sums[ch] / fill_level);
      end
      avg.pm1 = mean[0];
      avg.pm2_5 = mean[1];
      avg.pm4 = mean[2];
      avg.pm10 = mean[3];
      avg.held = fcwa_pkg::held_type'(fill_level);
      pending_averages = {pending_averages, avg};
   endfunction

   // Sample values weighted toward the edges of the field
   function automatic fcwa_pkg::sample_type pick_sample();
      int                   roll;
      fcwa_pkg::sample_type value;
      roll = $urandom_range(99);
      if (roll < 10) value = '0;
      else if (roll < 20) value = '1;
      else if (roll < 30) value = fcwa_pkg::sample_type'(10000);
      else if (roll < 65) value = fcwa_pkg::sample_type'($urandom_range(10000));
      else value = fcwa_pkg::sample_type'($urandom);
      return value;
   endfunction

   function automatic readings_type pick_readings();
      readings_type r;
      r.pm1 = pick_sample();
      r.pm2_5 = pick_sample();
      r.pm4 = pick_sample();
      r.pm10 = pick_sample();
      return r;
   endfunction

   function automatic readings_type make_readings(input int a, input int b, input int c,
                                                  input int d);
      readings_type r;
      r.pm1 = fcwa_pkg::sample_type'(a);
      r.pm2_5 = fcwa_pkg::sample_type'(b);
      r.pm4 = fcwa_pkg::sample_type'(c);
      r.pm10 = fcwa_pkg::sample_type'(d);
      return r;
   endfunction

   // Offer one item, optionally after random idle cycles; valid stays high after
   task automatic send_readings(input readings_type r);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.pm1_sample <= r.pm1;
      req_if.pm2_5_sample <= r.pm2_5;
      req_if.pm4_sample <= r.pm4;
      req_if.pm10_sample <= r.pm10;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_averages(r);
   endtask

   // Stop offering and wait for every outstanding result
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Length writes only with the block idle
   task automatic write_window_length(input fcwa_pkg::held_type len);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      set_window_model(len);
   endtask

   task automatic stream_random(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         send_readings(pick_readings());
      end
   endtask

   // Reset length of 1024: zero, full-scale and above-range readings
   task automatic test_default_window();
      send_readings(make_readings(0, 0, 0, 0));
      send_readings(make_readings(16383, 16383, 16383, 16383));
      send_readings(make_readings(10000, 1, 8192, 12345));
      drain_results();
   endtask

   // One-sample window: every item replaces the last
   task automatic test_single_sample_window();
      write_window_length(fcwa_pkg::held_type'(1));
      send_readings(make_readings(16383, 0, 16383, 0));
      send_readings(make_readings(0, 16383, 0, 16383));
      send_readings(make_readings(5, 10000, 1, 9999));
      drain_results();
   endtask

   // Zero acts as one, above 1024 saturates, 1024 itself
   task automatic test_length_limits();
      write_window_length(fcwa_pkg::held_type'(0));
      send_readings(make_readings(7, 100, 16383, 0));
      send_readings(make_readings(3, 200, 0, 16383));
      write_window_length(fcwa_pkg::held_type'(fcwa_pkg::MAX_WINDOW + 1));
      send_readings(make_readings(1, 2, 3, 4));
      send_readings(make_readings(10000, 10000, 10000, 10000));
      write_window_length(fcwa_pkg::held_type'(fcwa_pkg::MAX_WINDOW));
      send_readings(make_readings(16383, 8191, 4096, 1));
      drain_results();
   endtask

   // Rewriting the same length still empties the window
   task automatic test_rewrite_empties_window();
      write_window_length(fcwa_pkg::held_type'(3));
      send_readings(make_readings(900, 901, 902, 903));
      send_readings(make_readings(10, 20, 30, 40));
      send_readings(make_readings(16383, 0, 1, 2));
      send_readings(make_readings(0, 16383, 5000, 6000));
      send_readings(make_readings(11, 12, 13, 14));
      write_window_length(fcwa_pkg::held_type'(3));
      send_readings(make_readings(100, 100, 100, 100));
      send_readings(make_readings(51, 52, 53, 54));
      drain_results();
   endtask

   // Largest window filled and wrapped; PM10 at full scale tops out the sum
   task automatic test_full_window_wrap();
      readings_type r;
      int           i;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      write_window_length('1);
      for (i = 0; i < fcwa_pkg::MAX_WINDOW + 2; i++) begin
         r = pick_readings();
         if (i < fcwa_pkg::MAX_WINDOW) r.pm10 = '1;
         send_readings(r);
      end
      drain_results();
   endtask

   task automatic test_sender_gaps();
      sender_idle_pct = 86;
      receiver_stall_pct = 0;
      write_window_length(fcwa_pkg::held_type'(1));
      stream_random(10);
      write_window_length(fcwa_pkg::held_type'($urandom_range(2, 12)));
      stream_random(14);
      drain_results();
   endtask

   task automatic test_receiver_stalls();
      sender_idle_pct = 0;
      receiver_stall_pct = 86;
      write_window_length(fcwa_pkg::held_type'($urandom_range(2, 8)));
      stream_random(12);
      write_window_length(fcwa_pkg::held_type'($urandom_range(9, 12)));
      stream_random(12);
      drain_results();
   endtask

   task automatic test_both_idle();
      int seg;
      sender_idle_pct = 31;
      receiver_stall_pct = 31;
      for (seg = 0; seg < 3; seg++) begin
         write_window_length(fcwa_pkg::held_type'($urandom_range(2, 6)));
         stream_random(7);
      end
      drain_results();
   endtask

   // Receiver holds off long enough for the block to stall its input
   task automatic test_output_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      write_window_length(fcwa_pkg::held_type'($urandom_range(2, 8)));
      -> hold_off_kick;
      stream_random(12);
      receiver_stall_pct = 50;
      stream_random(8);
      drain_results();
      receiver_stall_pct = 0;
   endtask

   // Counted receiver hold-off
   initial begin
      forever begin
         @(hold_off_kick);
         hold_off_active <= 1'b1;
         repeat (HOLD_OFF_SPAN) @(posedge clock);
         hold_off_active <= 1'b0;
      end
   end

   // Result receiver: random stalls, or the counted hold-off
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_active) begin
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   task automatic check_field(input string label, input int want, input int got);
      if (want != got) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
         end
      end
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      averages_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_averages.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("%0t: unexpected result: expected none, actual held %0d", $time,
                        rsp_if.samples_held);
            end
         end else begin
            want = pending_averages.pop_front();
            check_field("pm1_average", want.pm1, rsp_if.pm1_average);
            check_field("pm2_5_average", want.pm2_5, rsp_if.pm2_5_average);
            check_field("pm4_average", want.pm4, rsp_if.pm4_average);
            check_field("pm10_average", want.pm10, rsp_if.pm10_average);
            check_field("samples_held", want.held, rsp_if.samples_held);
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.pm1_sample = '0;
      req_if.pm2_5_sample = '0;
      req_if.pm4_sample = '0;
      req_if.pm10_sample = '0;
      set_window_model(fcwa_pkg::WINDOW_RESET);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_default_window();
      test_single_sample_window();
      test_length_limits();
      test_rewrite_empties_window();
      test_full_window_wrap();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_output_backpressure();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_averages.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
